// File: hdl/fmc_pkg.sv
// ----------------------------------------------------------------------------
// fmc_pkg: shared types and constants of the first-match classifier
// Field widths, item codes, the token that moves down the cell chain and the
// prefix mask helper.
// ----------------------------------------------------------------------------
package fmc_pkg;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int SLOT_W    = 6;
  localparam int PFX_W     = 6;
  localparam int CNT_W     = 3;
  localparam int CFG_W     = 7;
  localparam int MAX_PORTS = 4;
  localparam int FULL_PFX  = 32;

  // parameter defaults
  localparam int RULES_DEF          = 64;
  localparam int PORTS_PER_RULE_DEF = 4;

  // item function codes
  typedef enum logic {
    FUNC_WRITE    = 1'b0,
    FUNC_CLASSIFY = 1'b1
  } fmc_func_t;

  // one item travelling down the cell chain, with its running search result
  typedef struct packed {
    logic                               valid;
    fmc_func_t                          func;
    logic [SLOT_W-1:0]                  slot;
    logic                               dir;
    logic                               rej;
    logic [ADDR_W-1:0]                  addr;
    logic [PFX_W-1:0]                   pfx;
    logic                               est;
    logic [CNT_W-1:0]                   cnt;
    logic [MAX_PORTS-1:0][PORT_W-1:0]   ports;
    logic                               found;
    logic                               hit_rej;
    logic [SLOT_W-1:0]                  hit_slot;
  } fmc_token_t;

  // address mask with the top pfx bits set; 32 and above is an exact match
  function automatic logic [ADDR_W-1:0] fmc_prefix_mask(input logic [PFX_W-1:0] pfx);
    logic [ADDR_W-1:0] mask;
    if (pfx == '0) begin
      mask = '0;
    end else if (pfx >= PFX_W'(FULL_PFX)) begin
      mask = '1;
    end else begin
      mask = ~({ADDR_W{1'b1}} >> pfx);
    end
    return mask;
  endfunction

endpackage

// File: hdl/fmc_ifs.sv
// ----------------------------------------------------------------------------
// fmc_ifs: stream channels of the first-match classifier
// Request channel (rule writes and packet headers) and result channel, both
// with valid/ready flow control.
// ----------------------------------------------------------------------------
interface fmc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [5:0]  rule_slot;
  logic        direction;
  logic        action_reject;
  logic [31:0] address;
  logic [5:0]  prefix_length;
  logic        established;
  logic [2:0]  port_count;
  logic [15:0] port_a;
  logic [15:0] port_b;
  logic [15:0] port_c;
  logic [15:0] port_d;

  modport source (
    output valid, func, rule_slot, direction, action_reject, address,
           prefix_length, established, port_count, port_a, port_b, port_c, port_d,
    input  ready
  );
  modport sink (
    input  valid, func, rule_slot, direction, action_reject, address,
           prefix_length, established, port_count, port_a, port_b, port_c, port_d,
    output ready
  );
endinterface

interface fmc_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic       verdict_reject;
  logic [5:0] hit_slot;

  modport source (
    output valid, matched, verdict_reject, hit_slot,
    input  ready
  );
  modport sink (
    input  valid, matched, verdict_reject, hit_slot,
    output ready
  );
endinterface

// File: hdl/firewall_first_match_classifier.sv
// ----------------------------------------------------------------------------
// firewall_first_match_classifier: first-match IPv4 prefix and port filter
// Rule cell chain; a request walks it one cell per cycle unless out_ch stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries rule writes (func 0) and packet headers (func 1); a transfer
//   happens when valid and ready are both high. out_ch returns one result per
//   packet header (matched, verdict_reject, hit_slot); rule writes give none.
//   cfg_we/cfg_wdata load rules_in_use; the user must write it only while no
//   request is in flight, as the block itself does not enforce this. A header
//   accepted into the first cell passes one cell register per rule slot and
//   then the result register before it shows on out_ch.
//   Throughput: one request per cycle while out_ch is not stalled, as the
//   chain moves one cell per cycle. Writes travel the chain in order with
//   headers, so a header sees every write accepted before it.
//   When out_ch is stalled with a result waiting, the whole chain holds and
//   in_ch.ready drops until the result is taken.
//   Reset clears the in-flight tokens, the result valid flag and rules_in_use;
//   rule contents are not cleared and must be written before they are used.
// ----------------------------------------------------------------------------
module firewall_first_match_classifier #(
  parameter int RULES          = fmc_pkg::RULES_DEF,
  parameter int PORTS_PER_RULE = fmc_pkg::PORTS_PER_RULE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fmc_in_if.sink                     in_ch,
  fmc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [fmc_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [fmc_pkg::CFG_W-1:0]  rules_in_use_r;
  logic                       advance;
  fmc_pkg::fmc_token_t        tok [0:RULES];
  fmc_pkg::fmc_token_t        tail;

  logic                       out_valid_r;
  logic                       out_matched_r;
  logic                       out_rej_r;
  logic [fmc_pkg::SLOT_W-1:0] out_slot_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules_in_use_r <= '0;
    end else if (cfg_we) begin
      rules_in_use_r <= cfg_wdata;
    end
  end

  // chain moves unless a result waits on a stalled output
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  // request into a chain token
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = in_ch.valid;
    tok[0].func     = fmc_pkg::fmc_func_t'(in_ch.func);
    tok[0].slot     = in_ch.rule_slot;
    tok[0].dir      = in_ch.direction;
    tok[0].rej      = in_ch.action_reject;
    tok[0].addr     = in_ch.address;
    tok[0].pfx      = in_ch.prefix_length;
    tok[0].est      = in_ch.established;
    tok[0].cnt      = in_ch.port_count;
    tok[0].ports[0] = in_ch.port_a;
    tok[0].ports[1] = in_ch.port_b;
    tok[0].ports[2] = in_ch.port_c;
    tok[0].ports[3] = in_ch.port_d;
  end

  // row of rule cells
  for (genvar i = 0; i < RULES; i++) begin : g_cell
    fmc_cell #(
      .IDX            (i),
      .RULES          (RULES),
      .PORTS_PER_RULE (PORTS_PER_RULE)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .advance      (advance),
      .rules_in_use (rules_in_use_r),
      .tok_i        (tok[i]),
      .tok_o        (tok[i+1])
    );
  end

  assign tail = tok[RULES];

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tail.valid && (tail.func == fmc_pkg::FUNC_CLASSIFY);
    end
  end

  // result payload, zero fields on a miss
  always_ff @(posedge clk) begin
    if (advance) begin
      out_matched_r <= tail.found;
      out_rej_r     <= tail.found && tail.hit_rej;
      out_slot_r    <= tail.found ? tail.hit_slot : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.matched        = out_matched_r;
  assign out_ch.verdict_reject = out_rej_r;
  assign out_ch.hit_slot       = out_slot_r;

  // a miss reports accept and slot zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_matched_r |-> !out_rej_r && (out_slot_r == '0))
    else $error("classifier: miss with nonzero verdict or slot");

  // a rule write leaving the chain gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    advance && tail.valid && (tail.func == fmc_pkg::FUNC_WRITE) |=> !out_valid_r)
    else $error("classifier: result from a rule write");

  // a header leaving the chain always gives a result
  a_header_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && tail.valid && (tail.func == fmc_pkg::FUNC_CLASSIFY) |=> out_valid_r)
    else $error("classifier: header lost at chain end");

endmodule

// File: hdl/fmc_cell.sv
// ----------------------------------------------------------------------------
// fmc_cell: one rule slot of the classifier chain
// Holds one rule, loads it when a write for its slot passes, checks passing
// packets against it and forwards every token to the next cell.
// ----------------------------------------------------------------------------
module fmc_cell #(
  parameter int IDX            = 0,
  parameter int RULES          = fmc_pkg::RULES_DEF,
  parameter int PORTS_PER_RULE = fmc_pkg::PORTS_PER_RULE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [fmc_pkg::CFG_W-1:0]    rules_in_use,
  input  fmc_pkg::fmc_token_t          tok_i,
  output fmc_pkg::fmc_token_t          tok_o
);

  localparam int IDX_W    = $clog2(RULES + 1);
  localparam int CMP_W    = (IDX_W > fmc_pkg::CFG_W ? IDX_W : fmc_pkg::CFG_W) + 1;
  localparam bit WRITABLE = (IDX < (1 << fmc_pkg::SLOT_W));

  // stored rule
  logic                                              dir_r;
  logic                                              rej_r;
  logic                                              est_r;
  logic [fmc_pkg::ADDR_W-1:0]                        addr_r;
  logic [fmc_pkg::ADDR_W-1:0]                        mask_r;
  logic [fmc_pkg::CNT_W-1:0]                         cnt_r;
  logic [PORTS_PER_RULE-1:0][fmc_pkg::PORT_W-1:0]    ports_r;

  // token register
  logic                 valid_r;
  fmc_pkg::fmc_token_t  pay_r;
  fmc_pkg::fmc_token_t  tok_nxt;

  logic                       rule_en;
  logic                       wr_en;
  logic                       port_hit;
  logic                       port_ok;
  logic                       match;
  logic [fmc_pkg::PFX_W-1:0]  pfx_clamp;
  logic [fmc_pkg::CNT_W-1:0]  cnt_clamp;

  // slot is searched when below the in-use count
  assign rule_en = (CMP_W'(rules_in_use) > CMP_W'(IDX));

  // rule write for this slot
  assign wr_en = advance && tok_i.valid && (tok_i.func == fmc_pkg::FUNC_WRITE) &&
                 WRITABLE && (tok_i.slot == fmc_pkg::SLOT_W'(IDX));

  assign pfx_clamp = (tok_i.pfx > fmc_pkg::PFX_W'(fmc_pkg::FULL_PFX)) ?
                     fmc_pkg::PFX_W'(fmc_pkg::FULL_PFX) : tok_i.pfx;
  assign cnt_clamp = (tok_i.cnt > fmc_pkg::CNT_W'(PORTS_PER_RULE)) ?
                     fmc_pkg::CNT_W'(PORTS_PER_RULE) : tok_i.cnt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dir_r  <= tok_i.dir;
      rej_r  <= tok_i.rej;
      est_r  <= tok_i.est;
      addr_r <= tok_i.addr;
      mask_r <= fmc_pkg::fmc_prefix_mask(pfx_clamp);
      cnt_r  <= cnt_clamp;
      for (int k = 0; k < PORTS_PER_RULE; k++) begin
        ports_r[k] <= tok_i.ports[k];
      end
    end
  end

  // port list check, packet port rides in the first port field
  always_comb begin
    port_hit = 1'b0;
    for (int k = 0; k < PORTS_PER_RULE; k++) begin
      if ((fmc_pkg::CNT_W'(k) < cnt_r) && (ports_r[k] == tok_i.ports[0])) begin
        port_hit = 1'b1;
      end
    end
    port_ok = (cnt_r == '0) || port_hit;
  end

  // full rule match
  assign match = (dir_r == tok_i.dir) &&
                 (((addr_r ^ tok_i.addr) & mask_r) == '0) &&
                 port_ok &&
                 !(est_r && !tok_i.est);

  // record the first hit, otherwise pass the token unchanged
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.valid && (tok_i.func == fmc_pkg::FUNC_CLASSIFY) && !tok_i.found &&
        rule_en && match) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.hit_rej  = rej_r;
      tok_nxt.hit_slot = fmc_pkg::SLOT_W'(IDX);
    end
  end

  // token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= tok_nxt.valid;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pay_r <= tok_nxt;
    end
  end

  always_comb begin
    tok_o       = pay_r;
    tok_o.valid = valid_r;
  end

  // an earlier hit is never lost or overwritten
  a_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    advance && tok_i.valid && tok_i.found |=>
      tok_o.valid && tok_o.found && (tok_o.hit_slot == $past(tok_i.hit_slot)))
    else $error("fmc_cell: earlier hit lost");

  // a slot past the in-use count never produces a hit
  a_unused_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    advance && tok_i.valid && !tok_i.found && !rule_en |=> !tok_o.found)
    else $error("fmc_cell: hit on a slot that is not in use");

endmodule

// File: tb/sv/fmc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmc_tb_pkg: rule table shadow and verdict scoreboard for the classifier
// Keeps a copy of the rule table and the search count. Each accepted request
// updates the copy (rule write) or queues the verdict it should get (packet),
// and each result transfer is checked against the oldest queued verdict.
// ----------------------------------------------------------------------------
package fmc_tb_pkg;
  import fmc_pkg::*;

  // one request as driven on the input channel
  typedef struct packed {
    fmc_func_t                        func;
    logic [SLOT_W-1:0]                slot;
    logic                             dir;
    logic                             rej;
    logic [ADDR_W-1:0]                addr;
    logic [PFX_W-1:0]                 pfx;
    logic                             est;
    logic [CNT_W-1:0]                 cnt;
    logic [MAX_PORTS-1:0][PORT_W-1:0] ports;
  } fmc_request_t;

  // one verdict as seen on the result channel
  typedef struct packed {
    logic              matched;
    logic              verdict_reject;
    logic [SLOT_W-1:0] hit_slot;
  } fmc_verdict_t;

  class fmc_verdict_board;
    logic                             rule_dir   [RULES_DEF];
    logic                             rule_rej   [RULES_DEF];
    logic [ADDR_W-1:0]                rule_addr  [RULES_DEF];
    logic [PFX_W-1:0]                 rule_pfx   [RULES_DEF];
    logic                             rule_est   [RULES_DEF];
    logic [CNT_W-1:0]                 rule_cnt   [RULES_DEF];
    logic [MAX_PORTS-1:0][PORT_W-1:0] rule_ports [RULES_DEF];
    logic [CFG_W-1:0]                 search_count;
    fmc_verdict_t                     verdict_q[$];
    int unsigned                      fail_count;

    function new();
      for (int s = 0; s < RULES_DEF; s++) begin
        rule_dir[s]   = 1'b0;
        rule_rej[s]   = 1'b0;
        rule_addr[s]  = '0;
        rule_pfx[s]   = '0;
        rule_est[s]   = 1'b0;
        rule_cnt[s]   = '0;
        rule_ports[s] = '0;
      end
      search_count = '0;
      fail_count   = 0;
    endfunction

    // top len bits set; zero length compares nothing
    function logic [ADDR_W-1:0] addr_mask(logic [PFX_W-1:0] len);
      if (len == '0) begin
        return '0;
      end
      if (len >= FULL_PFX) begin
        return '1;
      end
      return {ADDR_W{1'b1}} << (FULL_PFX - int'(len));
    endfunction

    function int unsigned searched_slots();
      return (search_count > RULES_DEF) ? RULES_DEF : int'(search_count);
    endfunction

    // does slot s accept this packet header
    function bit rule_hits(int unsigned s, fmc_request_t p);
      logic [ADDR_W-1:0] mask;
      bit                port_ok;
      if (rule_dir[s] != p.dir) begin
        return 1'b0;
      end
      mask = addr_mask(rule_pfx[s]);
      if ((rule_addr[s] & mask) != (p.addr & mask)) begin
        return 1'b0;
      end
      port_ok = (rule_cnt[s] == '0);
      for (int k = 0; k < MAX_PORTS; k++) begin
        if (k < int'(rule_cnt[s]) && rule_ports[s][k] == p.ports[0]) begin
          port_ok = 1'b1;
        end
      end
      if (!port_ok) begin
        return 1'b0;
      end
      if (!p.est && rule_est[s]) begin
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // accepted input transfer: store a rule or queue a verdict
    function void note_request(fmc_request_t r);
      fmc_verdict_t v;
      if (r.func == FUNC_WRITE) begin
        rule_dir[r.slot]   = r.dir;
        rule_rej[r.slot]   = r.rej;
        rule_addr[r.slot]  = r.addr;
        rule_pfx[r.slot]   = (r.pfx > FULL_PFX) ? PFX_W'(FULL_PFX) : r.pfx;
        rule_est[r.slot]   = r.est;
        rule_cnt[r.slot]   = (r.cnt > MAX_PORTS) ? CNT_W'(MAX_PORTS) : r.cnt;
        rule_ports[r.slot] = r.ports;
        return;
      end
      v = '0;
      for (int s = 0; s < int'(searched_slots()); s++) begin
        if (rule_hits(s, r)) begin
          v.matched        = 1'b1;
          v.verdict_reject = rule_rej[s];
          v.hit_slot       = SLOT_W'(s);
          break;
        end
      end
      verdict_q.push_back(v);
    endfunction

    // result transfer against the oldest queued verdict
    function void check_verdict(fmc_verdict_t got);
      fmc_verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("result with no packet waiting: matched %0b reject %0b hit_slot %0d",
               got.matched, got.verdict_reject, got.hit_slot);
        fail_count++;
        return;
      end
      want = verdict_q.pop_front();
      if (got.matched !== want.matched) begin
        $error("matched: expected %0b, got %0b", want.matched, got.matched);
        fail_count++;
      end
      if (got.verdict_reject !== want.verdict_reject) begin
        $error("verdict_reject: expected %0b, got %0b", want.verdict_reject,
               got.verdict_reject);
        fail_count++;
      end
      if (got.hit_slot !== want.hit_slot) begin
        $error("hit_slot: expected %0d, got %0d", want.hit_slot, got.hit_slot);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

endpackage

// File: tb/sv/firewall_first_match_classifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// firewall_first_match_classifier_test: first-match filter testbench
// Loads rule slots and sends packet headers through the request channel with
// random gaps and result back-pressure, and checks every verdict against a
// shadow of the rule table. A directed opening covers prefix and port
// corners, then random phases run at several search counts.
// ----------------------------------------------------------------------------
module firewall_first_match_classifier_test;
  import fmc_pkg::*;
  import fmc_tb_pkg::*;

  localparam int LATENCY     = RULES_DEF + 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 160;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               idle_on;
  int unsigned      cycle_count;
  fmc_verdict_board board;

  fmc_in_if  in_ch ();
  fmc_out_if out_ch ();

  firewall_first_match_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result back-pressure in short bursts
  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
      out_ch.ready <= 1'b1;
    end
  end

  // result transfers and run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      board.check_verdict('{out_ch.matched, out_ch.verdict_reject, out_ch.hit_slot});
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // every field random, function given
  function automatic fmc_request_t random_request(fmc_func_t f);
    fmc_request_t r;
    r.func  = f;
    r.slot  = SLOT_W'($urandom_range(0, RULES_DEF - 1));
    r.dir   = 1'($urandom_range(0, 1));
    r.rej   = 1'($urandom_range(0, 1));
    r.addr  = $urandom();
    r.pfx   = PFX_W'($urandom_range(0, 63));
    r.est   = 1'($urandom_range(0, 1));
    r.cnt   = CNT_W'($urandom_range(0, 7));
    for (int k = 0; k < MAX_PORTS; k++) begin
      r.ports[k] = PORT_W'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  // common service ports so rules and packets overlap
  function automatic logic [PORT_W-1:0] pick_port();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return PORT_W'(22);
      3:       return PORT_W'(80);
      4:       return PORT_W'(443);
      default: return PORT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic fmc_request_t rule_item(logic [SLOT_W-1:0] slot, logic dir, logic rej,
                                             logic [ADDR_W-1:0] addr, logic [PFX_W-1:0] pfx,
                                             logic est, logic [CNT_W-1:0] cnt,
                                             logic [MAX_PORTS-1:0][PORT_W-1:0] ports);
    fmc_request_t r;
    r       = random_request(FUNC_WRITE);
    r.slot  = slot;
    r.dir   = dir;
    r.rej   = rej;
    r.addr  = addr;
    r.pfx   = pfx;
    r.est   = est;
    r.cnt   = cnt;
    r.ports = ports;
    return r;
  endfunction

  function automatic fmc_request_t packet_item(logic dir, logic [ADDR_W-1:0] addr,
                                               logic [PORT_W-1:0] port, logic est);
    fmc_request_t r;
    r          = random_request(FUNC_CLASSIFY);
    r.dir      = dir;
    r.addr     = addr;
    r.ports[0] = port;
    r.est      = est;
    return r;
  endfunction

  // random but well-formed rule, with a few clamped prefixes and counts
  function automatic fmc_request_t random_rule(logic [SLOT_W-1:0] slot);
    fmc_request_t r;
    r      = random_request(FUNC_WRITE);
    r.slot = slot;
    if ($urandom_range(0, 1) == 0) begin
      r.addr[31:16] = {8'h0A, 6'd0, 2'($urandom_range(0, 3))};
    end
    case ($urandom_range(0, 9))
      0:       r.pfx = '0;
      1:       r.pfx = PFX_W'(FULL_PFX);
      2:       r.pfx = PFX_W'($urandom_range(33, 63));
      default: r.pfx = PFX_W'($urandom_range(1, 31));
    endcase
    r.cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(5, 7))
                                        : CNT_W'($urandom_range(0, 4));
    for (int k = 0; k < MAX_PORTS; k++) begin
      r.ports[k] = pick_port();
    end
    return r;
  endfunction

  // mostly headers aimed at a searched rule, the rest noise
  function automatic fmc_request_t random_packet();
    fmc_request_t      p;
    int unsigned       s;
    int unsigned       n;
    logic [ADDR_W-1:0] mask;
    p = random_request(FUNC_CLASSIFY);
    if (board.searched_slots() == 0 || $urandom_range(0, 3) == 0) begin
      return p;
    end
    s     = $urandom_range(0, board.searched_slots() - 1);
    mask  = board.addr_mask(board.rule_pfx[s]);
    p.dir = board.rule_dir[s];
    p.addr = (board.rule_addr[s] & mask) | (p.addr & ~mask);
    n = board.rule_cnt[s];
    if (n > 0 && $urandom_range(0, 4) != 0) begin
      p.ports[0] = board.rule_ports[s][$urandom_range(0, n - 1)];
    end else begin
      p.ports[0] = pick_port();
    end
    if (board.rule_est[s] && $urandom_range(0, 6) != 0) begin
      p.est = 1'b1;
    end
    return p;
  endfunction

  // one input transfer, with an optional gap before it
  task automatic send_request(input fmc_request_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= r.func;
    in_ch.rule_slot     <= r.slot;
    in_ch.direction     <= r.dir;
    in_ch.action_reject <= r.rej;
    in_ch.address       <= r.addr;
    in_ch.prefix_length <= r.pfx;
    in_ch.established   <= r.est;
    in_ch.port_count    <= r.cnt;
    in_ch.port_a        <= r.ports[0];
    in_ch.port_b        <= r.ports[1];
    in_ch.port_c        <= r.ports[2];
    in_ch.port_d        <= r.ports[3];
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_request(r);
  endtask

  // drain, let trailing rule writes leave the chain, then load the count
  task automatic drain_chain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_rule_count(input logic [CFG_W-1:0] n);
    drain_chain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.search_count = n;
  endtask

  initial begin
    logic [CFG_W-1:0] count;
    int unsigned      next_slot;
    board = new();
    cycle_count = 0;
    idle_on     = 1'b0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_WRITE;
    in_ch.rule_slot     <= '0;
    in_ch.direction     <= 1'b0;
    in_ch.action_reject <= 1'b0;
    in_ch.address       <= '0;
    in_ch.prefix_length <= '0;
    in_ch.established   <= 1'b0;
    in_ch.port_count    <= '0;
    in_ch.port_a        <= '0;
    in_ch.port_b        <= '0;
    in_ch.port_c        <= '0;
    in_ch.port_d        <= '0;
    out_ch.ready        <= 1'b1;
    repeat (4) @(posedge clk);
    rst_n   <= 1'b1;
    idle_on = 1'b1;

    // empty search: every packet misses
    send_request(packet_item(1'b0, 32'h0000_0000, 16'h0000, 1'b0));
    send_request(packet_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));

    // corner rules: /8 with two ports, exact with established, clamped
    // prefix and count, any address, long prefix, inbound catch-all
    send_request(rule_item(6'd0, 1'b0, 1'b0, 32'h0A00_0000, 6'd8, 1'b0, 3'd2,
                           {16'd0, 16'd0, 16'd443, 16'd80}));
    send_request(rule_item(6'd1, 1'b0, 1'b1, 32'hC0A8_0101, 6'd32, 1'b1, 3'd0,
                           {16'd7, 16'd6, 16'd5, 16'd4}));
    send_request(rule_item(6'd2, 1'b1, 1'b0, 32'hFFFF_FFFF, 6'd40, 1'b0, 3'd7,
                           {16'hFFFF, 16'd3, 16'd2, 16'd1}));
    send_request(rule_item(6'd3, 1'b1, 1'b1, 32'h1234_5678, 6'd0, 1'b0, 3'd1,
                           {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0}));
    send_request(rule_item(6'd4, 1'b0, 1'b0, 32'h0000_0000, 6'd63, 1'b1, 3'd4,
                           {16'd25, 16'd22, 16'hFFFF, 16'd0}));
    send_request(rule_item(6'd5, 1'b0, 1'b1, 32'hFFFF_FFFF, 6'd0, 1'b0, 3'd0,
                           {16'd0, 16'd0, 16'd0, 16'd0}));
    load_rule_count(CFG_W'(6));

    // headers against the corner rules
    send_request(packet_item(1'b0, 32'h0A01_0203, 16'd443, 1'b0));
    send_request(packet_item(1'b0, 32'h0A01_0203, 16'd8080, 1'b0));
    send_request(packet_item(1'b0, 32'hC0A8_0101, 16'd1234, 1'b0));
    send_request(packet_item(1'b0, 32'hC0A8_0101, 16'd1234, 1'b1));
    send_request(packet_item(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    send_request(packet_item(1'b1, 32'hFFFF_FFFE, 16'd0, 1'b0));
    send_request(packet_item(1'b1, 32'h0A00_0001, 16'd5, 1'b1));
    send_request(packet_item(1'b0, 32'h0000_0000, 16'd22, 1'b1));
    send_request(packet_item(1'b0, 32'h0000_0000, 16'd22, 1'b0));

    // fill the rest of the table while classifying
    next_slot = 6;
    while (next_slot < RULES_DEF) begin
      if ($urandom_range(0, 1) == 0) begin
        send_request(random_rule(SLOT_W'(next_slot)));
        next_slot++;
      end else begin
        send_request(random_packet());
      end
    end

    // random phases over several search counts
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       count = CFG_W'(RULES_DEF);
        1:       count = '1;
        2:       count = CFG_W'(1);
        3:       count = '0;
        default: count = CFG_W'($urandom_range(1, RULES_DEF));
      endcase
      load_rule_count(count);
      idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          send_request(random_rule(SLOT_W'($urandom_range(0, RULES_DEF - 1))));
        end else begin
          send_request(random_packet());
        end
      end
    end

    drain_chain();
    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
